@@ src/heightmap_neighbour_smoother_defines.svh @@
// assertion macros used by the rtl back end
`ifndef HEIGHTMAP_NEIGHBOUR_SMOOTHER_DEFINES_SVH
`define HEIGHTMAP_NEIGHBOUR_SMOOTHER_DEFINES_SVH

`ifndef ASSERT_OFF
`define HNS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HNS_NEVER(name, cond, msg) \
  `HNS_ASSERT(name, !(cond), msg)
`else
`define HNS_ASSERT(name, prop, msg)
`define HNS_NEVER(name, cond, msg)
`endif

`endif

@@ src/hns_pkg.sv @@
package hns_pkg;

  localparam int MAX_LAST_INDEX_DEF = 256;
  localparam int HW = 24;
  localparam int IW = 9;
  localparam int PAW = 3;
  localparam int DW = 32;
  localparam logic [0:0] REG_LAST_INDEX = 1'b0;
  localparam logic [IW-1:0] LAST_INDEX_RST = 9'd256;

  localparam int SUM_W = 28;
  localparam int N_W = 27;
  localparam int RECIP_W = 31;
  localparam int RECIP_SHIFT = 32;
  localparam int QW = N_W + RECIP_W - RECIP_SHIFT;
  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] CNT_CORNER = 4'd4;
  localparam logic [CNT_W-1:0] CNT_EDGE = 4'd6;
  localparam logic [CNT_W-1:0] CNT_INNER = 4'd9;

  typedef struct packed {
    logic wr;
    logic swap;
    logic [1:0] emits;
    logic signed [HW-1:0] height;
  } op_t;

  // floor(2^32 / cnt)
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      CNT_CORNER: m = 31'd1073741824;
      CNT_EDGE:   m = 31'd715827882;
      CNT_INNER:  m = 31'd477218588;
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [HW-1:0] v);
    return {{(SUM_W-HW){v[HW-1]}}, v};
  endfunction

endpackage

@@ src/hns_if.sv @@
interface hns_in_if;
  import hns_pkg::*;
  logic valid;
  logic ready;
  logic command;
  logic signed [HW-1:0] height;
  modport source (output valid, command, height, input ready);
  modport sink (input valid, command, height, output ready);
endinterface

interface hns_out_if;
  import hns_pkg::*;
  logic valid;
  logic ready;
  logic signed [HW-1:0] smoothed;
  logic [IW-1:0] row;
  logic [IW-1:0] column;
  logic last;
  modport source (output valid, smoothed, row, column, last, input ready);
  modport sink (input valid, smoothed, row, column, last, output ready);
endinterface

@@ src/hns_ram.sv @@
module hns_ram #(
  parameter int W = 24,
  parameter int D = 257
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/hns_queue.sv @@
module hns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hns_pkg::op_t   data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output hns_pkg::op_t   data_o
);
  import hns_pkg::*;

  op_t        slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

@@ src/hns_front.sv @@
module hns_front #(
  parameter int MAX_LAST_INDEX = hns_pkg::MAX_LAST_INDEX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic [$clog2(MAX_LAST_INDEX+2)-1:0] last_i,
  hns_in_if.sink                            in_i,
  input  logic                              full_i,
  output logic                              push_o,
  output hns_pkg::op_t                      op_o
);
  import hns_pkg::*;
  localparam int CW = $clog2(MAX_LAST_INDEX + 2);

  logic [CW-1:0] irow_q, icol_q, orow_q, ocol_q;
  logic acc, smp_ok, drn_ok, e1, e2, row_end;

  assign in_i.ready = !full_i;
  assign acc = in_i.valid && in_i.ready;

  always_comb begin
    smp_ok  = irow_q <= last_i && icol_q <= last_i;
    row_end = icol_q == last_i;
    e1 = irow_q != '0 && icol_q != '0;
    e2 = irow_q != '0 && row_end;
    drn_ok = irow_q > last_i && orow_q == last_i && ocol_q <= last_i;
    op_o.height = in_i.height;
    if (in_i.command) begin
      op_o.wr = 1'b0;
      op_o.swap = 1'b0;
      op_o.emits = 2'd1;
      push_o = acc && drn_ok;
    end else begin
      op_o.wr = 1'b1;
      op_o.swap = row_end;
      op_o.emits = e2 ? 2'd2 : (e1 ? 2'd1 : 2'd0);
      push_o = acc && smp_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irow_q <= '0;
      icol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else if (clear_i) begin
      irow_q <= '0;
      icol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else if (push_o) begin
      if (!in_i.command) begin
        if (row_end) begin
          icol_q <= '0;
          irow_q <= irow_q + CW'(1);
        end else begin
          icol_q <= icol_q + CW'(1);
        end
        if (e2) begin
          orow_q <= irow_q;
          ocol_q <= '0;
        end else if (e1) begin
          ocol_q <= icol_q;
        end
      end else if (ocol_q == last_i) begin
        // final point of the grid, start over
        irow_q <= '0;
        icol_q <= '0;
        orow_q <= '0;
        ocol_q <= '0;
      end else begin
        ocol_q <= ocol_q + CW'(1);
      end
    end
  end
endmodule

@@ src/hns_back.sv @@
`include "heightmap_neighbour_smoother_defines.svh"
module hns_back #(
  parameter int MAX_LAST_INDEX = hns_pkg::MAX_LAST_INDEX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic [$clog2(MAX_LAST_INDEX+2)-1:0] last_i,
  input  logic                              avail_i,
  input  hns_pkg::op_t                      op_i,
  output logic                              pop_o,
  hns_out_if.source                         out_o
);
  import hns_pkg::*;
  localparam int CW = $clog2(MAX_LAST_INDEX + 2);
  localparam int D = MAX_LAST_INDEX + 1;
  localparam int AW = $clog2(D);

  typedef enum logic [7:0] {
    B_IDLE  = 8'b0000_0001,
    B_WRITE = 8'b0000_0010,
    B_FETCH = 8'b0000_0100,
    B_LAST  = 8'b0000_1000,
    B_NORM  = 8'b0001_0000,
    B_MUL   = 8'b0010_0000,
    B_FIX   = 8'b0100_0000,
    B_OUT   = 8'b1000_0000
  } back_state_e;

  back_state_e state_q;
  op_t op_q;
  logic [1:0] emits_q, step_q;
  logic [CW-1:0] wcol_q, orow_q, ocol_q;
  logic sel_q, neg_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [N_W-1:0] n_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N_W+RECIP_W-1:0] prod_q;
  logic signed [HW-1:0] val_q, sleft_q, uleft_q, old_q;

  logic [1:0] bank_we;
  logic [HW-1:0] bank_rd [2];
  logic [HW-1:0] sm_rd;
  logic [CW-1:0] addr;
  logic sm_we, has_u, has_d, has_l, has_r, dm, d0, dp, do_out;
  logic signed [HW-1:0] rr, rn, sm;
  logic signed [SUM_W-1:0] add_rr, add_rn, add_sm, mag;
  logic [QW-1:0] q0, q;
  logic [QW+CNT_W-1:0] qd;
  logic [QW+CNT_W-1:0] rem;

  assign has_u = orow_q != '0;
  assign has_d = orow_q < last_i;
  assign has_l = ocol_q != '0;
  assign has_r = ocol_q < last_i;

  always_comb begin
    case (step_q)
      2'd0:    addr = has_l ? ocol_q - CW'(1) : ocol_q;
      2'd1:    addr = ocol_q;
      default: addr = has_r ? ocol_q + CW'(1) : ocol_q;
    endcase
  end

  // raw row being emitted sits in bank sel, the row after it in the other
  assign bank_we[0] = state_q == B_WRITE && sel_q;
  assign bank_we[1] = state_q == B_WRITE && !sel_q;
  assign sm_we = do_out;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    hns_ram #(.W(HW), .D(D)) u_raw (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (wcol_q[AW-1:0]),
      .wdata_i (op_q.height),
      .raddr_i (addr[AW-1:0]),
      .rdata_o (bank_rd[b])
    );
  end

  hns_ram #(.W(HW), .D(D)) u_smooth (
    .clk_i   (clk_i),
    .we_i    (sm_we),
    .waddr_i (ocol_q[AW-1:0]),
    .wdata_i (val_q),
    .raddr_i (addr[AW-1:0]),
    .rdata_o (sm_rd)
  );

  // offset of the column whose read data arrives this cycle
  always_comb begin
    dm = state_q == B_FETCH && step_q == 2'd1;
    d0 = state_q == B_FETCH && step_q == 2'd2;
    dp = state_q == B_LAST;
    rr = sel_q ? bank_rd[1] : bank_rd[0];
    rn = sel_q ? bank_rd[0] : bank_rd[1];
    sm = sm_rd;
    add_rr = (d0 || (dp && has_r)) ? sx(rr) : '0;
    add_sm = (has_u && (d0 || (dp && has_r))) ? sx(sm) : '0;
    add_rn = (has_d && ((dm && has_l) || d0 || (dp && has_r))) ? sx(rn) : '0;
    mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
    q0 = prod_q[RECIP_SHIFT +: QW];
    qd = q0 * cnt_q;
    rem = (QW+CNT_W)'(n_q) - qd;
    q = (rem >= (QW+CNT_W)'(cnt_q)) ? q0 + QW'(1) : q0;
    do_out = state_q == B_OUT && (!out_o.valid || out_o.ready);
  end

  assign pop_o = state_q == B_IDLE && avail_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) op_q <= op_i;
    if (state_q == B_FETCH && step_q == 2'd0) begin
      sum_q <= (has_l ? sx(sleft_q) : '0) + ((has_u && has_l) ? sx(uleft_q) : '0);
    end else if (state_q == B_FETCH || state_q == B_LAST) begin
      sum_q <= sum_q + add_rr + add_sm + add_rn;
    end
    if (d0) old_q <= sm;
    if (state_q == B_LAST) begin
      cnt_q <= ((has_u && has_d) && (has_l && has_r)) ? CNT_INNER :
               ((has_u && has_d) || (has_l && has_r)) ? CNT_EDGE : CNT_CORNER;
    end
    if (state_q == B_NORM) begin
      neg_q <= sum_q[SUM_W-1];
      n_q <= N_W'(mag) + N_W'(cnt_q >> 1);
    end
    if (state_q == B_MUL) prod_q <= n_q * recip(cnt_q);
    if (state_q == B_FIX) val_q <= neg_q ? -HW'(q) : HW'(q);
    if (do_out) begin
      out_o.smoothed <= val_q;
      out_o.row <= IW'(orow_q);
      out_o.column <= IW'(ocol_q);
      out_o.last <= orow_q == last_i && ocol_q == last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      emits_q <= '0;
      step_q <= '0;
      wcol_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      sel_q <= 1'b0;
      sleft_q <= '0;
      uleft_q <= '0;
      out_o.valid <= 1'b0;
    end else begin
      if (out_o.ready && !do_out) out_o.valid <= 1'b0;
      if (clear_i) begin
        wcol_q <= '0;
        orow_q <= '0;
        ocol_q <= '0;
      end
      case (state_q)
        B_IDLE: begin
          if (avail_i) begin
            emits_q <= op_i.emits;
            step_q <= '0;
            state_q <= op_i.wr ? B_WRITE : B_FETCH;
          end
        end
        B_WRITE: begin
          wcol_q <= op_q.swap ? '0 : wcol_q + CW'(1);
          if (emits_q != 2'd0) begin
            state_q <= B_FETCH;
          end else begin
            if (op_q.swap) sel_q <= ~sel_q;
            state_q <= B_IDLE;
          end
        end
        B_FETCH: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd2) state_q <= B_LAST;
        end
        B_LAST: state_q <= B_NORM;
        B_NORM: state_q <= B_MUL;
        B_MUL:  state_q <= B_FIX;
        B_FIX:  state_q <= B_OUT;
        B_OUT: begin
          if (do_out) begin
            out_o.valid <= 1'b1;
            uleft_q <= old_q;
            sleft_q <= val_q;
            emits_q <= emits_q - 2'd1;
            step_q <= '0;
            if (ocol_q == last_i) begin
              ocol_q <= '0;
              orow_q <= (orow_q == last_i) ? '0 : orow_q + CW'(1);
            end else begin
              ocol_q <= ocol_q + CW'(1);
            end
            if (emits_q == 2'd2) begin
              state_q <= B_FETCH;
            end else begin
              if (op_q.swap) sel_q <= ~sel_q;
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `HNS_ASSERT(a_out_load, (state_q == B_OUT && !out_o.valid) |=> out_o.valid, "result not loaded")
  `HNS_NEVER(a_bank_wr, bank_we[0] && bank_we[1], "both raw banks written")
  `HNS_ASSERT(a_fetch_end, (state_q == B_FETCH && step_q == 2'd2) |=> (state_q == B_LAST), "fetch overran")
  `HNS_NEVER(a_pop_busy, pop_o && state_q != B_IDLE, "pop outside idle")
endmodule

@@ src/heightmap_neighbour_smoother.sv @@
// channel   | dir | payload                          | accepted when
// in_i      | in  | command, height                  | valid && ready
// out_o     | out | smoothed, row, column, last      | valid && ready
// apb       | in  | paddr, pwdata (last_index at 0)  | psel && penable && pwrite
// the back end takes a new queue entry only once it is through with the last
// one: a sample is written, then each of its results is fetched, normalised
// and output by the sequencer with its single read port per row memory.
// the front end keeps accepting while the two-entry queue has room and a
// result waits in the output register. no clearing pass after reset.
module heightmap_neighbour_smoother #(
  parameter int MAX_LAST_INDEX = hns_pkg::MAX_LAST_INDEX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  hns_in_if.sink                  in_i,
  hns_out_if.source               out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [hns_pkg::PAW-1:0] paddr,
  input  logic [hns_pkg::DW-1:0]  pwdata,
  output logic [hns_pkg::DW-1:0]  prdata,
  output logic                    pready
);
  import hns_pkg::*;
  localparam int CW = $clog2(MAX_LAST_INDEX + 2);

  logic [IW-1:0] last_index_q;
  logic [CW-1:0] eff_last;
  logic cfg_wr, push, pop, full, avail;
  op_t op_in, op_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr[PAW-1:2] == REG_LAST_INDEX;
  assign prdata = (paddr[PAW-1:2] == REG_LAST_INDEX) ? DW'(last_index_q) : '0;

  always_comb begin
    if (last_index_q < IW'(2)) begin
      eff_last = CW'(2);
    end else if (32'(last_index_q) > MAX_LAST_INDEX) begin
      eff_last = CW'(MAX_LAST_INDEX);
    end else begin
      eff_last = CW'(last_index_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= LAST_INDEX_RST;
    end else if (cfg_wr) begin
      last_index_q <= pwdata[IW-1:0];
    end
  end

  hns_front #(.MAX_LAST_INDEX(MAX_LAST_INDEX)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_wr),
    .last_i  (eff_last),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .op_o    (op_in)
  );

  hns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (op_out)
  );

  hns_back #(.MAX_LAST_INDEX(MAX_LAST_INDEX)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_wr),
    .last_i  (eff_last),
    .avail_i (avail),
    .op_i    (op_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );
endmodule

@@ tb/sv/heightmap_neighbour_smoother_tb.sv @@
`timescale 1ns / 100ps

module heightmap_neighbour_smoother_tb;
  import hns_pkg::*;

  localparam int MAX_L = 256;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef enum logic {CMD_SAMPLE = 1'b0, CMD_DRAIN = 1'b1} cmd_e;

  typedef struct packed {
    logic signed [HW-1:0] smoothed;
    logic [IW-1:0]        row;
    logic [IW-1:0]        column;
    logic                 last;
  } point_t;

  typedef struct {
    cmd_e                 cmd;
    logic signed [HW-1:0] height;
    bit                   typed;
    point_t               want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;

  hns_in_if  in_ch ();
  hns_out_if out_ch ();

  heightmap_neighbour_smoother i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [HW-1:0] sm_row [MAX_L+1];
  logic signed [HW-1:0] raw_row [MAX_L+1];
  logic signed [HW-1:0] raw_next [MAX_L+1];
  logic signed [HW-1:0] sm_left, up_left;
  logic [IW-1:0] last_reg;
  int in_r, in_c, out_r, out_c;

  point_t expected_points [$];
  int errors = 0;
  int n_checked = 0;
  int n_grids = 0;
  longint cycles = 0;
  bit quiet = 1'b0;  // no idling while set
  bit typed_pending = 1'b0;
  bit in_held = 1'b0;  // valid still up from the last transaction
  point_t typed_want;

  function automatic void queue_point(point_t p);
    expected_points.insert(expected_points.size(), p);
  endfunction

  function automatic int grid_last();
    if (last_reg < 2) return 2;
    if (last_reg > MAX_L) return MAX_L;
    return int'(last_reg);
  endfunction

  function automatic logic signed [HW-1:0] mean_rounded(longint sum, longint cnt);
    if (sum >= 0) return HW'((sum + cnt / 2) / cnt);
    return HW'(-((-sum + cnt / 2) / cnt));
  endfunction

  function automatic point_t smooth_point(int lim);
    longint sum, cnt;
    point_t p;
    int i, j;
    i = out_r;
    j = out_c;
    sum = raw_row[j];
    cnt = 1;
    if (i >= 1) begin
      sum += sm_row[j]; cnt++;
      if (j >= 1) begin sum += up_left; cnt++; end
      if (j < lim) begin sum += sm_row[j+1]; cnt++; end
    end
    if (j >= 1) begin sum += sm_left; cnt++; end
    if (j < lim) begin sum += raw_row[j+1]; cnt++; end
    if (i < lim) begin
      sum += raw_next[j]; cnt++;
      if (j >= 1) begin sum += raw_next[j-1]; cnt++; end
      if (j < lim) begin sum += raw_next[j+1]; cnt++; end
    end
    p.smoothed = mean_rounded(sum, cnt);
    p.row = IW'(i);
    p.column = IW'(j);
    p.last = (i == lim && j == lim);
    up_left = sm_row[j];
    sm_row[j] = p.smoothed;
    sm_left = p.smoothed;
    if (j >= lim) begin
      out_c = 0;
      out_r = i + 1;
    end else begin
      out_c = j + 1;
    end
    return p;
  endfunction

  function automatic void predict_item(cmd_e cmd, logic signed [HW-1:0] h);
    int lim;
    lim = grid_last();
    if (cmd == CMD_SAMPLE) begin
      if (in_r > lim) return;
      raw_next[in_c] = h;
      if (in_r >= 1 && in_c >= 1) queue_point(smooth_point(lim));
      if (in_r >= 1 && in_c == lim) queue_point(smooth_point(lim));
      if (in_c == lim) begin
        in_c = 0;
        in_r++;
        for (int k = 0; k <= lim; k++) raw_row[k] = raw_next[k];
      end else begin
        in_c++;
      end
    end else begin
      if (in_r <= lim || out_r != lim || out_c > lim) return;
      queue_point(smooth_point(lim));
      if (out_r > lim) begin
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        n_grids++;
      end
    end
  endfunction

  // drop valid after the last transaction of a burst, at its falling edge
  task automatic in_release();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  task automatic apb_write(logic [PAW-1:0] addr, logic [DW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_grid(logic [IW-1:0] value);
    in_release();
    wait (expected_points.size() == 0);
    repeat (30) @(posedge clk_i);
    apb_write(PAW'(REG_LAST_INDEX) << 2, DW'(value));
    last_reg = value;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    // an index past the register list must be a no-op
    apb_write(PAW'(4), DW'($urandom));
  endtask

  task automatic send(cmd_e cmd, logic signed [HW-1:0] h);
    if (!in_held) @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.height <= h;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(cmd, h);
    @(negedge clk_i);
    in_held = 1'b1;
  endtask

  function automatic logic signed [HW-1:0] rand_height(int mode);
    case (mode)
      0: return HW'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
      default: return HW'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  // one full grid plus drains, with occasional noise
  task automatic run_grid(int lim, int mode);
    for (int k = 0; k < (lim + 1) * (lim + 1); k++) begin
      if ($urandom_range(99) < 3) send(CMD_DRAIN, rand_height(0));
      send(CMD_SAMPLE, rand_height(mode));
    end
    for (int k = 0; k < 3; k++) if ($urandom_range(1)) send(CMD_SAMPLE, rand_height(0));
    for (int k = 0; k <= lim; k++) send(CMD_DRAIN, rand_height(0));
  endtask

  // sink side
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 24);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      point_t got, want;
      got = '{out_ch.smoothed, out_ch.row, out_ch.column, out_ch.last};
      if (expected_points.size() == 0) begin
        $error("unexpected result transaction row %0d column %0d", got.row, got.column);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (typed_pending) begin
          if (typed_want !== want) begin
            $error("typed row disagrees with predictor");
            errors++;
          end
          typed_pending = 1'b0;
        end
        n_checked++;
        if (got.smoothed !== want.smoothed) begin
          $error("smoothed: expected %0d actual %0d", want.smoothed, got.smoothed);
          errors++;
        end
        if (got.row !== want.row) begin
          $error("row: expected %0d actual %0d", want.row, got.row);
          errors++;
        end
        if (got.column !== want.column) begin
          $error("column: expected %0d actual %0d", want.column, got.column);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  row_t directed [$];

  function automatic void add_row(cmd_e cmd, logic signed [HW-1:0] h, bit typed,
                                  point_t want);
    row_t r;
    r = '{cmd, h, typed, want};
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    int lim;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SAMPLE;
    in_ch.height = '0;
    last_reg = LAST_INDEX_RST;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    sm_left = '0; up_left = '0;
    for (int k = 0; k <= MAX_L; k++) begin
      sm_row[k] = '0; raw_row[k] = '0; raw_next[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: 3x3 grid; early drain, extremes, a sample past the end, drains
    set_grid(9'd0);  // below the minimum acts as 2
    add_row(CMD_DRAIN, 24'sd5, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sh7FFFFF, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sh7FFFFF, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sh7FFFFF, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sh7FFFFF, 1'b0, '0);
    // first result: corner of four maximal samples
    add_row(CMD_SAMPLE, 24'sh7FFFFF, 1'b1, '{24'sh7FFFFF, 9'd0, 9'd0, 1'b0});
    add_row(CMD_SAMPLE, -24'sh800000, 1'b0, '0);
    add_row(CMD_SAMPLE, -24'sh800000, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sd1, 1'b0, '0);
    add_row(CMD_SAMPLE, -24'sd1, 1'b0, '0);
    add_row(CMD_SAMPLE, 24'sd3, 1'b0, '0);
    add_row(CMD_DRAIN, 24'sd0, 1'b0, '0);
    add_row(CMD_DRAIN, 24'sd0, 1'b0, '0);
    add_row(CMD_DRAIN, 24'sd0, 1'b0, '0);
    add_row(CMD_DRAIN, 24'sd0, 1'b0, '0);
    foreach (directed[k]) begin
      if (directed[k].typed) begin
        in_release();
        wait (expected_points.size() == 0);
        typed_pending = 1'b1;
        typed_want = directed[k].want;
      end
      send(directed[k].cmd, directed[k].height);
    end

    // random grids over several sizes, extremes included
    quiet = 1'b1;
    run_grid(2, 2);
    quiet = 1'b0;
    for (int g = 0; g < 40; g++) begin
      lim = $urandom_range(2, 6);
      set_grid(IW'(lim));
      run_grid(lim, $urandom_range(2));
    end
    set_grid(9'd511);  // above the maximum acts as 256
    set_grid(9'd3);
    // abandon a grid midway, then restart by a write
    for (int k = 0; k < 7; k++) send(CMD_SAMPLE, rand_height(0));
    set_grid(9'd256);
    for (int k = 0; k < 600; k++) send(CMD_SAMPLE, rand_height(0));
    set_grid(9'd2);
    run_grid(2, 1);

    in_release();
    wait (expected_points.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("checked %0d smoothed points over %0d completed grids", n_checked, n_grids);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
